FILE: design/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH  = 8;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // command broadcast to every cell
   typedef struct packed {
      logic              en;
      op_type            op;
      logic [DATA_W-1:0] key;
   } cell_ctrl_type;

endpackage

FILE: design/cdq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_req_if / cdq_rsp_if
// Valid/ready channels for deque requests and results.
// ----------------------------------------------------------------------------
interface cdq_req_if;
   logic                   valid;
   logic                   ready;
   cdq_pkg::op_type        req_type;
   logic signed [31:0]     key_value;

   modport source (output valid, req_type, key_value, input ready);
   modport sink   (input valid, req_type, key_value, output ready);
endinterface

interface cdq_rsp_if;
   logic                   valid;
   logic                   ready;
   cdq_pkg::status_type    status;
   logic signed [31:0]     removed_value;
   logic                   is_full;
   logic                   is_empty;

   modport source (output valid, status, removed_value, is_full, is_empty, input ready);
   modport sink   (input valid, status, removed_value, is_full, is_empty, output ready);
endinterface

FILE: design/cdq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_cell
// One slot of the deque: holds an entry and its occupied bit, and shifts
// toward either neighbor on front operations.
// ----------------------------------------------------------------------------
module cdq_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  cdq_pkg::cell_ctrl_type        ctrl,
   input  logic [cdq_pkg::DATA_W-1:0]    left_data,
   input  logic                          left_valid,
   input  logic [cdq_pkg::DATA_W-1:0]    right_data,
   input  logic                          right_valid,
   output logic [cdq_pkg::DATA_W-1:0]    data,
   output logic                          valid,
   output logic                          is_tail
);
   import cdq_pkg::*;

   logic [DATA_W-1:0] data_ff, data_in;
   logic              valid_ff, valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.en) begin
         case (ctrl.op)
            OP_PUSH_FRONT: begin
               data_in  = left_data;
               valid_in = left_valid;
            end
            OP_PUSH_REAR: begin
               // first free slot after the tail
               if (!valid_ff && left_valid) begin
                  data_in  = ctrl.key;
                  valid_in = 1'b1;
               end
            end
            OP_POP_FRONT: begin
               data_in  = right_data;
               valid_in = right_valid;
            end
            OP_POP_REAR: begin
               if (valid_ff && !right_valid) begin
                  valid_in = 1'b0;
               end
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign valid   = valid_ff;
   assign is_tail = valid_ff && !right_valid;

endmodule

FILE: design/circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH entries built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The deque takes one request per clock while results are taken as they come,
// and returns each result in the cycle after the request transfer, from an output
// register. A new request is taken in the same cycle as the waiting result's
// transfer and is held off for as long as that result stalls. Entry 0 of the
// cell row is always the front: front inserts and removes shift the whole row
// by one cell, rear inserts write the first free cell, and a rear removal reads
// the tail cell found by comparing each cell's occupied bit with its neighbor's.
// Inserts into a full deque return overflow and removes from an empty one
// return underflow, leaving the contents unchanged.
module circular_deque (
   input logic          clock,
   input logic          reset,
   cdq_req_if.sink      req_ch,
   cdq_rsp_if.source    rsp_ch
);
   import cdq_pkg::*;

   cell_ctrl_type     ctrl;
   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]  occ;
   logic [DEPTH-1:0]  tail;

   logic              fire;
   logic              full, empty;
   status_type        status_in, status_ff;
   logic [DATA_W-1:0] rear_val, removed_in, removed_ff;
   logic              full_in, full_ff, empty_in, empty_ff;
   logic              rsp_valid_ff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;
   assign full         = occ[DEPTH-1];
   assign empty        = !occ[0];

   always_comb begin
      rear_val = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_val = rear_val | (tail[i] ? cell_data[i] : '0);
      end
   end

   always_comb begin
      status_in  = ST_DONE;
      removed_in = '0;
      full_in    = full;
      empty_in   = empty;
      case (req_ch.req_type)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (full) begin
               status_in = ST_OVERFLOW;
            end else begin
               full_in  = occ[DEPTH-2];
               empty_in = 1'b0;
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (empty) begin
               status_in = ST_UNDERFLOW;
            end else begin
               removed_in = (req_ch.req_type == OP_POP_FRONT) ? cell_data[0] : rear_val;
               full_in    = 1'b0;
               empty_in   = !occ[1];
            end
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   assign ctrl.en  = fire && (status_in == ST_DONE);
   assign ctrl.op  = req_ch.req_type;
   assign ctrl.key = unsigned'(req_ch.key_value);

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] l_data, r_data;
      logic              l_valid, r_valid;

      // the row ends look like a full neighbor holding the key on the left
      // and an empty neighbor on the right
      if (g == 0) begin : g_first
         assign l_data  = ctrl.key;
         assign l_valid = 1'b1;
      end else begin : g_mid_l
         assign l_data  = cell_data[g-1];
         assign l_valid = occ[g-1];
      end
      if (g == DEPTH-1) begin : g_last
         assign r_data  = '0;
         assign r_valid = 1'b0;
      end else begin : g_mid_r
         assign r_data  = cell_data[g+1];
         assign r_valid = occ[g+1];
      end

      cdq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .left_data   (l_data),
         .left_valid  (l_valid),
         .right_data  (r_data),
         .right_valid (r_valid),
         .data        (cell_data[g]),
         .valid       (occ[g]),
         .is_tail     (tail[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
         full_ff    <= full_in;
         empty_ff   <= empty_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = status_ff;
   assign rsp_ch.removed_value = signed'(removed_ff);
   assign rsp_ch.is_full       = full_ff;
   assign rsp_ch.is_empty      = empty_ff;

`ifndef NO_ASSERTIONS
   // occupied cells always form a prefix of the row
   a_occ_prefix: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, occ} + {{DEPTH{1'b0}}, 1'b1}))
      else $error("occupied cells not contiguous from the front");

   a_refused_stable: assert property (@(posedge clock) disable iff (reset)
      (fire && status_in != ST_DONE) |=> $stable(occ))
      else $error("refused request changed the contents");

   a_push_front_key: assert property (@(posedge clock) disable iff (reset)
      (fire && req_ch.req_type == OP_PUSH_FRONT && !full)
      |=> cell_data[0] == $past(unsigned'(req_ch.key_value)))
      else $error("front insert did not land in the front cell");

   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_ch.is_full == occ[DEPTH-1]) && (rsp_ch.is_empty == !occ[0]))
      else $error("reported flags disagree with the cell row");
`endif

endmodule

FILE: tb/sv/circular_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Drives front and rear inserts and removals into the deque with random
// gaps and result stalls, predicts every status, removed value and the
// full/empty flags from a ring copy, and checks each result transfer.
// ----------------------------------------------------------------------------
module circular_deque_tb;
   import cdq_pkg::*;

   typedef struct {
      status_type        status;
      logic [DATA_W-1:0] removed;
      logic              full;
      logic              empty;
   } deque_result_type;

   logic clock = 1'b0;
   logic reset;

   cdq_req_if req_bus ();
   cdq_rsp_if rsp_bus ();

   circular_deque dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ring copy of the deque contents
   logic [DATA_W-1:0] ring_copy [DEPTH];
   int                head_pos   = 0;
   int                tail_pos   = 0;
   bit                ring_empty = 1'b1;

   deque_result_type expected_results[$];
   int unsigned      mismatches = 0;
   bit               idle_on    = 1'b1;

   function automatic int step_fwd(int p);
      return (p + 1 >= DEPTH) ? 0 : p + 1;
   endfunction

   function automatic int step_back(int p);
      return (p == 0) ? DEPTH - 1 : p - 1;
   endfunction

   function automatic bit ring_is_full();
      return !ring_empty && step_fwd(tail_pos) == head_pos;
   endfunction

   function automatic deque_result_type apply_request(op_type op, logic [DATA_W-1:0] key);
      deque_result_type res;
      bit               last_one;
      res.status  = ST_DONE;
      res.removed = '0;
      if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
         if (ring_is_full()) begin
            res.status = ST_OVERFLOW;
         end else if (ring_empty) begin
            // first entry always lands at slot zero
            head_pos     = 0;
            tail_pos     = 0;
            ring_empty   = 1'b0;
            ring_copy[0] = key;
         end else if (op == OP_PUSH_FRONT) begin
            head_pos            = step_back(head_pos);
            ring_copy[head_pos] = key;
         end else begin
            tail_pos            = step_fwd(tail_pos);
            ring_copy[tail_pos] = key;
         end
      end else if (ring_empty) begin
         res.status = ST_UNDERFLOW;
      end else begin
         last_one = (head_pos == tail_pos);
         if (op == OP_POP_FRONT) begin
            res.removed = ring_copy[head_pos];
            head_pos    = step_fwd(head_pos);
         end else begin
            res.removed = ring_copy[tail_pos];
            tail_pos    = step_back(tail_pos);
         end
         if (last_one) begin
            head_pos   = 0;
            tail_pos   = 0;
            ring_empty = 1'b1;
         end
      end
      res.full  = ring_is_full();
      res.empty = ring_empty;
      return res;
   endfunction

   // one request transfer; valid stays high afterwards until the next call
   task automatic send_request(input op_type op, input logic [DATA_W-1:0] key);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= op;
      req_bus.key_value <= key;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_results.push_back(apply_request(op, key));
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic wait_for_drain();
      stop_requests();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // result side: random stall before each transfer while idle_on is set
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      forever begin
         stall = idle_on ? $urandom_range(0, 8) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin : check_results
      deque_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with no request pending");
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %s, got %s", want.status.name(),
                      rsp_bus.status.name());
               mismatches++;
            end
            if (rsp_bus.removed_value !== want.removed) begin
               $error("removed_value: expected %0d, got %0d",
                      $signed(want.removed), rsp_bus.removed_value);
               mismatches++;
            end
            if (rsp_bus.is_full !== want.full) begin
               $error("is_full: expected %b, got %b", want.full, rsp_bus.is_full);
               mismatches++;
            end
            if (rsp_bus.is_empty !== want.empty) begin
               $error("is_empty: expected %b, got %b", want.empty, rsp_bus.is_empty);
               mismatches++;
            end
         end
      end
   end

   task automatic test_empty_underflow();
      send_request(OP_POP_FRONT, $urandom);
      send_request(OP_POP_REAR, $urandom);
      wait_for_drain();
   endtask

   // alternate ends so the front pointer wraps below slot zero
   task automatic test_fill_overflow();
      send_request(OP_PUSH_REAR,  32'h7FFF_FFFF);
      send_request(OP_PUSH_FRONT, 32'h8000_0000);
      send_request(OP_PUSH_REAR,  32'h0000_0000);
      send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      send_request(OP_PUSH_REAR,  32'h5555_5555);
      send_request(OP_PUSH_FRONT, 32'hAAAA_AAAA);
      send_request(OP_PUSH_REAR,  32'h1234_5678);
      send_request(OP_PUSH_FRONT, 32'h8765_4321);
      send_request(OP_PUSH_FRONT, 32'hDEAD_BEEF);
      send_request(OP_PUSH_REAR,  32'h0BAD_F00D);
      wait_for_drain();
   endtask

   task automatic test_drain_both_ends();
      repeat (DEPTH / 2) send_request(OP_POP_FRONT, $urandom);
      repeat (DEPTH / 2) send_request(OP_POP_REAR, $urandom);
      send_request(OP_POP_REAR, $urandom);
      send_request(OP_POP_FRONT, $urandom);
      wait_for_drain();
   endtask

   // phases with different insert bias walk the deque between empty and full
   task automatic test_random_traffic();
      int unsigned push_pct;
      op_type      op;
      for (int phase = 0; phase < 12; phase++) begin
         idle_on = (phase % 4 != 3);
         case (phase % 6)
            0:       push_pct = 90;
            1:       push_pct = 10;
            2:       push_pct = 50;
            3:       push_pct = 75;
            4:       push_pct = 25;
            default: push_pct = 55;
         endcase
         repeat (150) begin
            if ($urandom_range(1, 100) <= push_pct)
               op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            else
               op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
            send_request(op, $urandom);
         end
         wait_for_drain();
      end
      idle_on = 1'b1;
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.req_type  = OP_PUSH_FRONT;
      req_bus.key_value = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_empty_underflow();
      test_fill_overflow();
      test_drain_both_ends();
      test_random_traffic();

      repeat (4) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("PASS circular_deque");
      else
         $display("FAIL circular_deque");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL circular_deque");
      $finish;
   end

endmodule

FILE: filelist.f
design/cdq_pkg.sv
design/cdq_if.sv
design/cdq_cell.sv
design/circular_deque.sv
tb/sv/circular_deque_tb.sv
